[sv/xxh64_pkg.sv]
`timescale 1ns / 1ps
// xxh64_pkg: primes, rotate helper and the multiplier request type of the
// xxHash64 stream hasher. Used by xxh64_mul and xxhash64_stream_hasher.
package xxh64_pkg;

	localparam logic [63:0] P1 = 64'd11400714785074694791;
	localparam logic [63:0] P2 = 64'd14029467366897019727;
	localparam logic [63:0] P3 = 64'd1609587929392839161;
	localparam logic [63:0] P4 = 64'd9650029242287828579;
	localparam logic [63:0] P5 = 64'd2870177450012600261;

	localparam int unsigned WordBytes  = 8;
	localparam int unsigned LongLength = 32;

	// Rotate left by a nonzero amount.
	function automatic logic [63:0] rol64(input logic [63:0] x, input logic [5:0] r);
		logic [6:0] rs;
		rs = 7'd64 - {1'b0, r};
		return (x << r) | (x >> rs);
	endfunction

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

endpackage

[sv/xxh64_mul.sv]
`timescale 1ns / 1ps
// xxh64_mul: low 64 bits of a 64x64 product, built from one shared 32x32
// multiplier, one partial product per step. Depends on xxh64_pkg (mul_req_t).
module xxh64_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  xxh64_pkg::mul_req_t  req,
	output logic                 done,
	output logic [63:0]          product
);

	logic        busy_q;
	logic [1:0]  step_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] sum_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;

	// Step 0: lo*lo, step 1: hi*lo, step 2: lo*hi (cross terms land in the upper half).
	always_comb begin
		unique case (step_q)
			2'd0: begin
				ma = a_q[31:0];
				mb = b_q[31:0];
			end
			2'd1: begin
				ma = a_q[63:32];
				mb = b_q[31:0];
			end
			default: begin
				ma = a_q[31:0];
				mb = b_q[63:32];
			end
		endcase
	end

	assign prod = 64'(ma) * 64'(mb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				sum_q <= prod;
			end else begin
				sum_q[63:32] <= sum_q[63:32] + prod[31:0];
			end
		end
	end

	assign done    = done_q;
	assign product = sum_q;

endmodule

[sv/xxhash64_stream_hasher.sv]
`timescale 1ns / 1ps
// xxhash64_stream_hasher: xxHash64 digest of a word stream, top level.
// Depends on xxh64_pkg and xxh64_mul.
// Usage
//   Input channel (in_valid/in_ready): one beat carries data_word, byte_count
//   and last_word. Earlier beats count eight bytes; the last beat counts
//   byte_count bytes, saturated to eight. Output channel (out_valid/out_ready):
//   one hash_value beat per last word. APB: seed at address 0, 64-bit data,
//   pready tied high; write it only while the block is idle.
// Sequencing
//   Each 64-bit multiply runs on one shared 32x32 multiplier (issue, three
//   partial products, write back); in_ready is high only when idle. A
//   buffered word is only stored; a word that completes a 32-byte stripe
//   runs four lane rounds, two multiplies each. A last word runs the stripe
//   rounds if it completes a stripe, the lane merge on messages of 32 bytes
//   or more, the length add, a round per held or full tail word, a 4-byte
//   tail step, a step per single tail byte, the avalanche and the output
//   register load.
// Reset and stall: reset clears the message, loads the lanes from seed zero
//   and drops any pending result. A digest holds in its final state while the
//   previous one is not taken, and in_ready stays low meanwhile.
module xxhash64_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	// digest
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value
);

	// sequencer states
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_STR_A  = 5'd1;   // acc += lane word * P2
	localparam logic [4:0] S_STR_B  = 5'd2;   // acc = rol31(acc) * P1
	localparam logic [4:0] S_CONV   = 5'd3;   // h += rol(acc[i])
	localparam logic [4:0] S_MRG_A  = 5'd4;   // t = acc[i] * P2
	localparam logic [4:0] S_MRG_B  = 5'd5;   // h ^= rol31(t) * P1
	localparam logic [4:0] S_MRG_C  = 5'd6;   // h = h * P1 + P4
	localparam logic [4:0] S_LEN    = 5'd7;   // h += length
	localparam logic [4:0] S_TAIL_A = 5'd8;   // t = word * P2
	localparam logic [4:0] S_TAIL_B = 5'd9;   // h ^= rol31(t) * P1
	localparam logic [4:0] S_TAIL_C = 5'd10;  // h = rol27(h) * P1 + P4
	localparam logic [4:0] S_W4_A   = 5'd11;  // h ^= low half * P1
	localparam logic [4:0] S_W4_B   = 5'd12;  // h = rol23(h) * P2 + P3
	localparam logic [4:0] S_BYTE_A = 5'd13;  // h ^= byte * P5
	localparam logic [4:0] S_BYTE_B = 5'd14;  // h = rol11(h) * P1
	localparam logic [4:0] S_AV_A   = 5'd15;  // h = (h ^ h>>33) * P2
	localparam logic [4:0] S_AV_B   = 5'd16;  // h = (h ^ h>>29) * P3
	localparam logic [4:0] S_FIN    = 5'd17;  // out = h ^ h>>32

	localparam logic [1:0] LastLane = 2'd3;
	localparam logic [3:0] FullWord = 4'(xxh64_pkg::WordBytes);
	localparam logic [3:0] HalfWord = 4'(xxh64_pkg::WordBytes / 2);

	// control state
	logic [4:0]  state_q;
	logic        issued_q;
	logic [1:0]  idx_q;
	logic [2:0]  pos_q;
	logic [1:0]  held_q;
	logic [63:0] len_q;
	logic [63:0] seed_q;
	logic        last_q;
	logic        stripe_q;
	logic [63:0] acc_q [4];
	logic        out_valid_q;

	// payload
	logic [63:0] buf_q [3];
	logic [63:0] word_q;
	logic [3:0]  n_q;
	logic [63:0] h_q;
	logic [63:0] t_q;
	logic [63:0] hash_q;

	// datapath signals
	logic                 accept;
	logic                 cfg_wr;
	logic [3:0]           n_sat;
	logic                 stripe_now;
	logic                 long_now;
	logic                 mul_state;
	logic [63:0]          op_a;
	logic [63:0]          op_k;
	logic                 mul_done;
	logic [63:0]          prod;
	xxh64_pkg::mul_req_t  mul_req;
	logic [1:0]           src_lim;
	logic [63:0]          lane_src;
	logic [2:0]           tail_cnt;
	logic [4:0]           short_next;
	logic [5:0]           conv_rot;
	logic                 out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[3] == 1'b0);
	assign pready   = 1'b1;
	assign prdata   = (paddr[3] == 1'b0) ? seed_q : 64'd0;

	assign n_sat      = (byte_count > FullWord) ? FullWord : byte_count;
	assign stripe_now = last_word && (n_sat == FullWord) && (held_q == LastLane);
	assign long_now   = (len_q >= 64'(xxh64_pkg::LongLength)) || stripe_now;

	// Stripe lanes 0..2 and tail words come from the buffer, the rest from the word.
	assign src_lim  = (state_q == S_STR_A) ? LastLane : held_q;
	assign lane_src = (idx_q < src_lim) ? buf_q[idx_q] : word_q;

	assign tail_cnt = {1'b0, held_q} + {2'b00, (n_q == FullWord)};
	assign out_free = !out_valid_q || out_ready;

	// Where the short tail starts once the whole-word rounds are done.
	always_comb begin
		priority if (n_q == FullWord) begin
			short_next = S_AV_A;
		end else if (n_q >= HalfWord) begin
			short_next = S_W4_A;
		end else if (n_q != 4'd0) begin
			short_next = S_BYTE_A;
		end else begin
			short_next = S_AV_A;
		end
	end

	always_comb begin
		unique case (idx_q)
			2'd0:    conv_rot = 6'd1;
			2'd1:    conv_rot = 6'd7;
			2'd2:    conv_rot = 6'd12;
			default: conv_rot = 6'd18;
		endcase
	end

	// Operand select for the shared multiplier.
	always_comb begin
		mul_state = 1'b1;
		op_a      = h_q;
		op_k      = xxh64_pkg::P1;
		unique case (state_q)
			S_STR_A: begin
				op_a = lane_src;
				op_k = xxh64_pkg::P2;
			end
			S_STR_B: op_a = xxh64_pkg::rol64(acc_q[idx_q], 6'd31);
			S_MRG_A: begin
				op_a = acc_q[idx_q];
				op_k = xxh64_pkg::P2;
			end
			S_MRG_B: op_a = xxh64_pkg::rol64(t_q, 6'd31);
			S_MRG_C: op_a = h_q;
			S_TAIL_A: begin
				op_a = lane_src;
				op_k = xxh64_pkg::P2;
			end
			S_TAIL_B: op_a = xxh64_pkg::rol64(t_q, 6'd31);
			S_TAIL_C: op_a = xxh64_pkg::rol64(h_q, 6'd27);
			S_W4_A:   op_a = {32'd0, word_q[31:0]};
			S_W4_B: begin
				op_a = xxh64_pkg::rol64(h_q, 6'd23);
				op_k = xxh64_pkg::P2;
			end
			S_BYTE_A: begin
				op_a = {56'd0, word_q[{pos_q, 3'b000} +: 8]};
				op_k = xxh64_pkg::P5;
			end
			S_BYTE_B: op_a = xxh64_pkg::rol64(h_q, 6'd11);
			S_AV_A: begin
				op_a = h_q ^ (h_q >> 33);
				op_k = xxh64_pkg::P2;
			end
			S_AV_B: begin
				op_a = h_q ^ (h_q >> 29);
				op_k = xxh64_pkg::P3;
			end
			default: mul_state = 1'b0;
		endcase
	end

	assign mul_req.start = mul_state && !issued_q;
	assign mul_req.a     = op_a;
	assign mul_req.b     = op_k;

	xxh64_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (prod)
	);

	// Sequencer, counters, lanes and seed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			idx_q       <= 2'd0;
			pos_q       <= 3'd0;
			held_q      <= 2'd0;
			len_q       <= 64'd0;
			seed_q      <= 64'd0;
			last_q      <= 1'b0;
			stripe_q    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q[0]    <= xxh64_pkg::P1 + xxh64_pkg::P2;
			acc_q[1]    <= xxh64_pkg::P2;
			acc_q[2]    <= 64'd0;
			acc_q[3]    <= 64'd0 - xxh64_pkg::P1;
		end else begin
			// Drop the result once taken, unless a new one loads this cycle.
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			if (mul_req.start) begin
				issued_q <= 1'b1;
			end
			if (mul_done) begin
				issued_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= 2'd0;
						if (!last_word) begin
							len_q  <= len_q + 64'(xxh64_pkg::WordBytes);
							last_q <= 1'b0;
							if (held_q != LastLane) begin
								held_q <= held_q + 2'd1;
							end else begin
								state_q <= S_STR_A;
							end
						end else begin
							len_q    <= len_q + 64'(n_sat);
							last_q   <= 1'b1;
							stripe_q <= stripe_now;
							priority if (stripe_now) begin
								state_q <= S_STR_A;
							end else if (long_now) begin
								state_q <= S_CONV;
							end else begin
								state_q <= S_LEN;
							end
						end
					end
				end
				S_STR_A: begin
					if (mul_done) begin
						acc_q[idx_q] <= acc_q[idx_q] + prod;
						state_q      <= S_STR_B;
					end
				end
				S_STR_B: begin
					if (mul_done) begin
						acc_q[idx_q] <= prod;
						idx_q        <= idx_q + 2'd1;
						if (idx_q != LastLane) begin
							state_q <= S_STR_A;
						end else begin
							held_q  <= 2'd0;
							state_q <= last_q ? S_CONV : S_IDLE;
						end
					end
				end
				S_CONV: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == LastLane) begin
						state_q <= S_MRG_A;
					end
				end
				S_MRG_A: begin
					if (mul_done) begin
						state_q <= S_MRG_B;
					end
				end
				S_MRG_B: begin
					if (mul_done) begin
						state_q <= S_MRG_C;
					end
				end
				S_MRG_C: begin
					if (mul_done) begin
						idx_q   <= idx_q + 2'd1;
						state_q <= (idx_q == LastLane) ? S_LEN : S_MRG_A;
					end
				end
				S_LEN: begin
					idx_q <= 2'd0;
					pos_q <= 3'd0;
					priority if (stripe_q) begin
						state_q <= S_AV_A;
					end else if (tail_cnt != 3'd0) begin
						state_q <= S_TAIL_A;
					end else begin
						state_q <= short_next;
					end
				end
				S_TAIL_A: begin
					if (mul_done) begin
						state_q <= S_TAIL_B;
					end
				end
				S_TAIL_B: begin
					if (mul_done) begin
						state_q <= S_TAIL_C;
					end
				end
				S_TAIL_C: begin
					if (mul_done) begin
						if (({1'b0, idx_q} + 3'd1) < tail_cnt) begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_TAIL_A;
						end else begin
							state_q <= short_next;
						end
					end
				end
				S_W4_A: begin
					if (mul_done) begin
						state_q <= S_W4_B;
					end
				end
				S_W4_B: begin
					if (mul_done) begin
						pos_q   <= 3'(HalfWord);
						state_q <= (n_q > HalfWord) ? S_BYTE_A : S_AV_A;
					end
				end
				S_BYTE_A: begin
					if (mul_done) begin
						state_q <= S_BYTE_B;
					end
				end
				S_BYTE_B: begin
					if (mul_done) begin
						pos_q   <= pos_q + 3'd1;
						state_q <= (({1'b0, pos_q} + 4'd1) < n_q) ? S_BYTE_A : S_AV_A;
					end
				end
				S_AV_A: begin
					if (mul_done) begin
						state_q <= S_AV_B;
					end
				end
				S_AV_B: begin
					if (mul_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// Hold until the output register is free, then reopen the message.
					if (out_free) begin
						out_valid_q <= 1'b1;
						held_q      <= 2'd0;
						len_q       <= 64'd0;
						last_q      <= 1'b0;
						stripe_q    <= 1'b0;
						acc_q[0]    <= seed_q + xxh64_pkg::P1 + xxh64_pkg::P2;
						acc_q[1]    <= seed_q + xxh64_pkg::P2;
						acc_q[2]    <= seed_q;
						acc_q[3]    <= seed_q - xxh64_pkg::P1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// User keeps seed writes to idle, unenforced; reload lanes if no message open.
			if (cfg_wr) begin
				seed_q <= pwdata;
				if ((len_q == 64'd0) && (held_q == 2'd0)) begin
					acc_q[0] <= pwdata + xxh64_pkg::P1 + xxh64_pkg::P2;
					acc_q[1] <= pwdata + xxh64_pkg::P2;
					acc_q[2] <= pwdata;
					acc_q[3] <= pwdata - xxh64_pkg::P1;
				end
			end
		end
	end

	// Payload: buffered words, running hash, temporaries, output word.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					word_q <= data_word;
					n_q    <= n_sat;
					if (!last_word && (held_q != LastLane)) begin
						buf_q[held_q] <= data_word;
					end
					if (last_word) begin
						h_q <= long_now ? 64'd0 : (seed_q + xxh64_pkg::P5);
					end
				end
			end
			S_CONV:   h_q <= h_q + xxh64_pkg::rol64(acc_q[idx_q], conv_rot);
			S_LEN:    h_q <= h_q + len_q;
			S_MRG_A, S_TAIL_A: begin
				if (mul_done) begin
					t_q <= prod;
				end
			end
			S_MRG_B, S_TAIL_B, S_W4_A, S_BYTE_A: begin
				if (mul_done) begin
					h_q <= h_q ^ prod;
				end
			end
			S_MRG_C, S_TAIL_C: begin
				if (mul_done) begin
					h_q <= prod + xxh64_pkg::P4;
				end
			end
			S_W4_B: begin
				if (mul_done) begin
					h_q <= prod + xxh64_pkg::P3;
				end
			end
			S_BYTE_B, S_AV_A, S_AV_B: begin
				if (mul_done) begin
					h_q <= prod;
				end
			end
			S_FIN: begin
				if (out_free) begin
					hash_q <= h_q ^ (h_q >> 32);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule
